// ===== src/rcfd_pkg.sv =====
package rcfd_pkg;

    // Frame header bytes
    localparam logic [7:0] HDR_FIRST  = 8'h20;
    localparam logic [7:0] HDR_SECOND = 8'h40;

    // Channel layout and thresholds
    localparam int unsigned CHANNELS    = 10;
    localparam int unsigned FIRST_CHAN  = 2;
    localparam logic [15:0] RAW_LOW     = 16'd1000;
    localparam logic [15:0] RAW_HIGH    = 16'd2000;

    // Scale limits
    localparam logic signed [7:0] STICK_MIN = -8'sd100;
    localparam logic signed [7:0] STICK_MAX = 8'sd100;
    localparam logic [6:0]        POT_MIN   = 7'd0;
    localparam logic [6:0]        POT_MAX   = 7'd100;
    localparam logic [7:0]        STICK_MID = 8'd100;

    // Reciprocal of five in 10-bit fraction; exact floor for offsets below 1024
    localparam logic [7:0] RECIP_FIVE = 8'd205;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_TAKEOFF = 2'd1,
        CMD_LAND    = 2'd2
    } flight_cmd_t;

    typedef struct packed {
        logic signed [7:0] stick;
        logic [6:0]        pot;
    } scaled_t;

endpackage

// ===== src/rcfd_cell.sv =====
module rcfd_cell
    import rcfd_pkg::*;
(
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] byte_in,
    output logic [7:0] byte_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Take the neighbor's byte on a shift, hold otherwise
    always_comb
    begin
        byte_next = shift ? byte_in : byte_reg;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

endmodule

// ===== src/rcfd_scale.sv =====
module rcfd_scale
    import rcfd_pkg::*;
(
    input  logic [15:0] raw,
    output scaled_t     scaled
);

    logic [9:0]  offset;
    logic [17:0] product;
    logic [7:0]  quot5;
    logic [15:0] diff;

    // Offset above the low end; only meaningful strictly inside the range
    assign diff    = raw - RAW_LOW;
    assign offset  = diff[9:0];
    assign product = {8'd0, offset} * {10'd0, RECIP_FIVE};
    assign quot5   = product[17:10];

    // Saturate outside the range, scale inside it
    always_comb
    begin
        if (raw <= RAW_LOW)
        begin
            scaled.stick = STICK_MIN;
            scaled.pot   = POT_MIN;
        end
        else if (raw >= RAW_HIGH)
        begin
            scaled.stick = STICK_MAX;
            scaled.pot   = POT_MAX;
        end
        else
        begin
            scaled.stick = $signed(quot5 - STICK_MID);
            scaled.pot   = quot5[7:1];
        end
    end

endmodule

// ===== src/rc_frame_decoder_with_flight_command.sv =====
// RC receiver frame decoder with flight command.
//
// Input channel: one received byte per beat on rx_byte (in_valid/in_ready).
// The block hunts for the header 0x20, 0x40 and collects a frame of
// FRAME_BYTES bytes in a row of byte cells that shift on every beat.
// Output channel: one decoded beat (out_valid/out_ready) per completed frame,
// carrying four sticks, two pots, four switches and a flight command.
//
// Throughput: one byte per cycle while in_ready is high. The last frame byte is
// taken from the port straight into the capture stage with the raw channels,
// and the result then passes through the scaling stage into the output register.
//
// Reset clears the frame position, the flying flag and both stage valids;
// the block starts out hunting for a header and not flying.
// When the receiver stalls, the result holds in the output register and the
// next result waits in the capture stage; while both are full, in_ready
// stays low until the output beat is taken.
module rc_frame_decoder_with_flight_command
    import rcfd_pkg::*;
#(
    parameter int FRAME_BYTES = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [7:0] stick_1,
    output logic signed [7:0] stick_2,
    output logic signed [7:0] stick_3,
    output logic signed [7:0] stick_4,
    output logic [6:0]        pot_5,
    output logic [6:0]        pot_6,
    output logic              toggle_a,
    output logic              toggle_b,
    output logic              toggle_c,
    output logic              toggle_d,
    output logic [1:0]        flight_command
);

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam int CHAIN = FRAME_BYTES - 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    logic              accept;
    logic              frame_done;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              flying_reg, flying_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_move;
    logic              out_valid_reg, out_valid_next;

    logic [7:0]        cell_q [CHAIN];
    logic [7:0]        frame_byte [FRAME_BYTES];
    logic [15:0]       raw_chan [CHANNELS];

    logic [15:0]       raw_reg [6];
    logic [3:0]        sw_reg;
    flight_cmd_t       cmd_reg;
    flight_cmd_t       cmd_next;
    logic              sw_a_now;

    scaled_t           scaled [6];

    logic signed [7:0] stick_reg [4];
    logic [6:0]        pot_reg [2];
    logic [3:0]        sw_out_reg;
    flight_cmd_t       cmd_out_reg;

    // Handshake
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    // Row of byte cells; cell 0 takes the incoming byte
    generate
        for (genvar i = 0; i < CHAIN; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                rcfd_cell u_cell (
                    .clk      (clk),
                    .shift    (accept),
                    .byte_in  (rx_byte),
                    .byte_out (cell_q[i])
                );
            end
            else
            begin : g_body
                rcfd_cell u_cell (
                    .clk      (clk),
                    .shift    (accept),
                    .byte_in  (cell_q[i-1]),
                    .byte_out (cell_q[i])
                );
            end
        end
    endgenerate

    // Frame byte k sits in cell FRAME_BYTES-2-k; the last byte is on the port
    generate
        for (genvar k = 0; k < FRAME_BYTES; k++)
        begin : g_fbyte
            if (k == FRAME_BYTES - 1)
            begin : g_last
                assign frame_byte[k] = rx_byte;
            end
            else
            begin : g_stored
                assign frame_byte[k] = cell_q[FRAME_BYTES - 2 - k];
            end
        end
        for (genvar c = 0; c < CHANNELS; c++)
        begin : g_raw
            assign raw_chan[c] = {frame_byte[FIRST_CHAN + 2*c + 1],
                                  frame_byte[FIRST_CHAN + 2*c]};
        end
    endgenerate

    // Header hunt and frame position
    always_comb
    begin
        pos_next   = pos_reg;
        frame_done = 1'b0;
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                pos_next = (rx_byte == HDR_FIRST) ? POS_W'(1) : '0;
            end
            else if (pos_reg == POS_W'(1))
            begin
                pos_next = (rx_byte == HDR_SECOND) ? POS_W'(2) : '0;
            end
            else if (pos_reg == POS_LAST)
            begin
                pos_next   = '0;
                frame_done = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // Flight command from switch A and the flying flag
    assign sw_a_now = (raw_chan[6] >= RAW_HIGH);

    always_comb
    begin
        flying_next = flying_reg;
        cmd_next    = CMD_NONE;
        if (frame_done)
        begin
            if (sw_a_now && !flying_reg)
            begin
                cmd_next    = CMD_TAKEOFF;
                flying_next = 1'b1;
            end
            else if (!sw_a_now && flying_reg)
            begin
                cmd_next    = CMD_LAND;
                flying_next = 1'b0;
            end
        end
    end

    // Stage valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (frame_done)
        begin
            s1_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            flying_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            flying_reg    <= flying_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture raw channels, switches and command on frame completion
    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            for (int j = 0; j < 6; j++)
            begin
                raw_reg[j] <= raw_chan[j];
            end
            for (int j = 0; j < 4; j++)
            begin
                sw_reg[j] <= (raw_chan[6 + j] >= RAW_HIGH);
            end
            cmd_reg <= cmd_next;
        end
    end

    // Scaling stage
    generate
        for (genvar s = 0; s < 6; s++)
        begin : g_scale
            rcfd_scale u_scale (
                .raw    (raw_reg[s]),
                .scaled (scaled[s])
            );
        end
    endgenerate

    // Load the output register as the capture stage advances
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int j = 0; j < 4; j++)
            begin
                stick_reg[j] <= scaled[j].stick;
            end
            pot_reg[0]  <= scaled[4].pot;
            pot_reg[1]  <= scaled[5].pot;
            sw_out_reg  <= sw_reg;
            cmd_out_reg <= cmd_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stick_1        = stick_reg[0];
    assign stick_2        = stick_reg[1];
    assign stick_3        = stick_reg[2];
    assign stick_4        = stick_reg[3];
    assign pot_5          = pot_reg[0];
    assign pot_6          = pot_reg[1];
    assign toggle_a       = sw_out_reg[0];
    assign toggle_b       = sw_out_reg[1];
    assign toggle_c       = sw_out_reg[2];
    assign toggle_d       = sw_out_reg[3];
    assign flight_command = cmd_out_reg;

    // A completed frame never lands on a full capture stage
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> (!s1_valid_reg || s1_move))
        else $error("frame completed while capture stage was full");

    // A completed frame shows up in the capture stage next cycle
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> s1_valid_reg)
        else $error("completed frame not captured");

    // Takeoff only with switch A on, land only with it off
    a_takeoff_sw: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cmd_out_reg == CMD_TAKEOFF) |-> toggle_a)
        else $error("takeoff without switch A");

    a_land_sw: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cmd_out_reg == CMD_LAND) |-> !toggle_a)
        else $error("land with switch A on");

    // Position stays within the frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("frame position out of range");

endmodule

// ===== test/rcfd_frame_checker.sv =====
module rcfd_frame_checker
    import rcfd_pkg::*;
#(
    parameter int FRAME_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic signed [7:0] stick_1,
    input  logic signed [7:0] stick_2,
    input  logic signed [7:0] stick_3,
    input  logic signed [7:0] stick_4,
    input  logic [6:0]        pot_5,
    input  logic [6:0]        pot_6,
    input  logic              toggle_a,
    input  logic              toggle_b,
    input  logic              toggle_c,
    input  logic              toggle_d,
    input  logic [1:0]        flight_command,
    output int                mismatches,
    output int                pending,
    output int                frames_checked
);

    typedef struct packed {
        logic signed [7:0] s1;
        logic signed [7:0] s2;
        logic signed [7:0] s3;
        logic signed [7:0] s4;
        logic [6:0]        p5;
        logic [6:0]        p6;
        logic              sa;
        logic              sb;
        logic              sc;
        logic              sd;
        flight_cmd_t       cmd;
    } decoded_frame_t;

    // Shadow copy of the frame collector
    logic [5:0]     byte_pos;
    logic [7:0]     frame_bytes [0:FRAME_LEN-1];
    logic           flying;
    decoded_frame_t decoded_q [$];

    function automatic logic [15:0] raw_chan(input int ch);
        return {frame_bytes[FIRST_CHAN + 2 * ch + 1], frame_bytes[FIRST_CHAN + 2 * ch]};
    endfunction

    // Scale a stick channel to -100..100, rounding down
    function automatic logic signed [7:0] stick_scale(input logic [15:0] raw);
        int r;
        int v;
        r = raw;
        v = ((r - 1000) * 200) / 1000 - 100;
        if (v < int'(STICK_MIN))
            v = STICK_MIN;
        if (v > int'(STICK_MAX))
            v = STICK_MAX;
        return v[7:0];
    endfunction

    // Scale a pot channel to 0..100
    function automatic logic [6:0] pot_scale(input logic [15:0] raw);
        int r;
        int v;
        r = raw;
        v = ((r - 1000) * 100) / 1000;
        if (v < 0)
            v = 0;
        if (v > int'(POT_MAX))
            v = POT_MAX;
        return v[6:0];
    endfunction

    // Advance the collector by one accepted byte; queue a decoded frame on completion
    task automatic collect_byte(input logic [7:0] b);
        decoded_frame_t f;
        if (byte_pos == 0 && b != HDR_FIRST)
            byte_pos = 0;
        else if (byte_pos == 1 && b != HDR_SECOND)
            byte_pos = 0;
        else
        begin
            frame_bytes[byte_pos] = b;
            byte_pos = byte_pos + 1;
            if (byte_pos == FRAME_LEN)
            begin
                byte_pos = 0;
                f.s1 = stick_scale(raw_chan(0));
                f.s2 = stick_scale(raw_chan(1));
                f.s3 = stick_scale(raw_chan(2));
                f.s4 = stick_scale(raw_chan(3));
                f.p5 = pot_scale(raw_chan(4));
                f.p6 = pot_scale(raw_chan(5));
                f.sa = raw_chan(6) >= RAW_HIGH;
                f.sb = raw_chan(7) >= RAW_HIGH;
                f.sc = raw_chan(8) >= RAW_HIGH;
                f.sd = raw_chan(9) >= RAW_HIGH;
                if (f.sa && !flying)
                begin
                    f.cmd = CMD_TAKEOFF;
                    flying = 1'b1;
                end
                else if (!f.sa && flying)
                begin
                    f.cmd = CMD_LAND;
                    flying = 1'b0;
                end
                else
                    f.cmd = CMD_NONE;
                decoded_q.push_back(f);
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Predict on each input beat, compare on each output beat
    always @(posedge clk or negedge rst_n)
    begin
        decoded_frame_t want;
        if (!rst_n)
        begin
            byte_pos = 0;
            flying = 1'b0;
            decoded_q.delete();
            mismatches = 0;
            frames_checked = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                collect_byte(rx_byte);
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, %s %0d %0d %0d %0d",
                             $time, "expected none, actual", stick_1, stick_2, stick_3,
                             stick_4);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("stick_1", $signed(want.s1), $signed(stick_1));
                    check_field("stick_2", $signed(want.s2), $signed(stick_2));
                    check_field("stick_3", $signed(want.s3), $signed(stick_3));
                    check_field("stick_4", $signed(want.s4), $signed(stick_4));
                    check_field("pot_5", want.p5, pot_5);
                    check_field("pot_6", want.p6, pot_6);
                    check_field("toggle_a", want.sa, toggle_a);
                    check_field("toggle_b", want.sb, toggle_b);
                    check_field("toggle_c", want.sc, toggle_c);
                    check_field("toggle_d", want.sd, toggle_d);
                    check_field("flight_command", want.cmd, flight_command);
                    frames_checked++;
                end
            end
        end
        pending = decoded_q.size();
    end

endmodule

// ===== test/tb_rc_frame_decoder_with_flight_command.sv =====
module tb_rc_frame_decoder_with_flight_command;
    import rcfd_pkg::*;

    localparam int FRAME_LEN   = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic signed [7:0] stick_1;
    logic signed [7:0] stick_2;
    logic signed [7:0] stick_3;
    logic signed [7:0] stick_4;
    logic [6:0]        pot_5;
    logic [6:0]        pot_6;
    logic              toggle_a;
    logic              toggle_b;
    logic              toggle_c;
    logic              toggle_d;
    logic [1:0]        flight_command;

    int mismatches;
    int pending;
    int frames_checked;

    int          send_idle;
    int          recv_idle;
    int          bytes_sent;
    int          frames_sent;
    int          cycle_count;
    logic [15:0] chan_raw [0:CHANNELS-1];

    rc_frame_decoder_with_flight_command #(
        .FRAME_BYTES(FRAME_LEN)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stick_1(stick_1),
        .stick_2(stick_2),
        .stick_3(stick_3),
        .stick_4(stick_4),
        .pot_5(pot_5),
        .pot_6(pot_6),
        .toggle_a(toggle_a),
        .toggle_b(toggle_b),
        .toggle_c(toggle_c),
        .toggle_d(toggle_d),
        .flight_command(flight_command)
    );

    rcfd_frame_checker #(
        .FRAME_LEN(FRAME_LEN)
    ) CHECK (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .stick_1(stick_1),
        .stick_2(stick_2),
        .stick_3(stick_3),
        .stick_4(stick_4),
        .pot_5(pot_5),
        .pot_6(pot_6),
        .toggle_a(toggle_a),
        .toggle_b(toggle_b),
        .toggle_c(toggle_c),
        .toggle_d(toggle_d),
        .flight_command(flight_command),
        .mismatches(mismatches),
        .pending(pending),
        .frames_checked(frames_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit reached with %0d results outstanding", $time, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stall the result side at random
    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle);

    // Drive one byte beat, idling first at random; returns at the next falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send header, the ten channels in chan_raw, and random trailing bytes
    task automatic send_frame();
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            send_byte(chan_raw[ch][7:0]);
            send_byte(chan_raw[ch][15:8]);
        end
        for (int i = FIRST_CHAN + 2 * CHANNELS; i < FRAME_LEN; i++)
            send_byte(8'($urandom));
        frames_sent++;
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(990, 1010));
            2:       return 16'($urandom_range(1990, 2010));
            3:       return 16'($urandom_range(0, 40));
            default: return 16'($urandom_range(900, 2100));
        endcase
    endfunction

    task automatic fill_channels(input logic [15:0] stick_raw, input logic [15:0] pot_raw,
                                 input logic [15:0] sw_raw);
        for (int ch = 0; ch < CHANNELS; ch++)
            chan_raw[ch] = (ch < 4) ? stick_raw : (ch < 6) ? pot_raw : sw_raw;
    endtask

    // Mostly well-formed frames with random content, some noise, broken headers and cut frames
    task automatic run_phase(input int s_idle, input int r_idle, input int n_bytes);
        int target;
        int roll;
        int cut;
        target       = bytes_sent + n_bytes;
        send_idle    = s_idle;
        recv_idle    = r_idle;
        while (bytes_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 78)
            begin
                for (int ch = 0; ch < CHANNELS; ch++)
                    chan_raw[ch] = pick_raw();
                send_frame();
            end
            else if (roll < 86)
                send_byte(8'($urandom));
            else if (roll < 94)
            begin
                send_byte(HDR_FIRST);
                send_byte($urandom_range(0, 1) ? HDR_FIRST : 8'($urandom));
            end
            else
            begin
                // Cut a frame short; the collector absorbs what follows
                cut = $urandom_range(2, 20);
                send_byte(HDR_FIRST);
                send_byte(HDR_SECOND);
                for (int i = 0; i < cut; i++)
                    send_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        send_idle   = 19;
        recv_idle   = 53;
        bytes_sent  = 0;
        frames_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Drop bad first bytes, then bad second bytes, including a repeated first header
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(8'h41);

        // Lowest raw values, switches off while landed
        fill_channels(16'h0000, 16'h0000, 16'h0000);
        send_frame();
        // Highest raw values, switch A on gives takeoff
        fill_channels(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame();
        // Scale midpoints and switch threshold, stay flying
        fill_channels(16'd1500, 16'd1500, RAW_HIGH);
        chan_raw[1] = 16'd999;
        chan_raw[2] = 16'd2000;
        chan_raw[3] = 16'd1004;
        chan_raw[5] = 16'd2000;
        send_frame();
        // Just below the threshold, switch A off gives land
        fill_channels(RAW_LOW, 16'd1009, 16'd1999);
        chan_raw[4] = 16'd1010;
        send_frame();

        run_phase(19, 53, 350);
        run_phase(53, 19, 350);
        run_phase(0, 0, 350);

        // Drain outstanding results, then settle
        in_valid <= 1'b0;
        recv_idle = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Sent %0d bytes (%0d framed sends) across three idle mixes;", bytes_sent,
                 frames_sent);
        $display("compared %0d decoded frames, %0d mismatches.", frames_checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
